/* rtl/bap_pkg.sv */
package bap_pkg;

    // Fixed field widths of the ports
    localparam int SAMPLE_W   = 16;
    localparam int PERIOD_W   = 19;
    localparam int MISMATCH_W = 12;
    localparam int WLEN_W     = 11;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd882;

    // Bit map unit operations
    typedef logic [1:0] bm_op_t;
    localparam bm_op_t BM_FILL  = 2'd0;
    localparam bm_op_t BM_CLEAR = 2'd1;
    localparam bm_op_t BM_COUNT = 2'd2;

    typedef struct packed {
        logic   go;
        bm_op_t op;
    } bm_cmd_t;

endpackage

/* rtl/bap_div.sv */
module bap_div #(
    parameter int FRAC_BITS = 8,
    localparam int QW = FRAC_BITS + 1,
    localparam int KW = $clog2(FRAC_BITS + 2)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          go,
    input  logic [bap_pkg::SAMPLE_W-1:0]  mag,
    input  logic [bap_pkg::SAMPLE_W-1:0]  span,
    output logic                          done,
    output logic [QW-1:0]                 quo
);

    logic                         busy_reg;
    logic                         done_reg;
    logic                         first_reg;
    logic [KW-1:0]                cnt_reg;
    logic [bap_pkg::SAMPLE_W:0]   rem_reg;
    logic [bap_pkg::SAMPLE_W-1:0] span_reg;
    logic [QW-1:0]                quo_reg;

    logic [bap_pkg::SAMPLE_W:0]   trial;
    logic                         ge;

    // Restoring division, one quotient bit a cycle; the first step takes the integer bit
    assign trial = first_reg ? rem_reg : {rem_reg[bap_pkg::SAMPLE_W-1:0], 1'b0};
    assign ge    = trial >= {1'b0, span_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                cnt_reg   <= KW'(QW);
                rem_reg   <= {1'b0, mag};
                span_reg  <= span;
                quo_reg   <= '0;
            end else if (busy_reg) begin
                rem_reg   <= ge ? (trial - {1'b0, span_reg}) : trial;
                quo_reg   <= {quo_reg[QW-2:0], ge};
                first_reg <= 1'b0;
                cnt_reg   <= cnt_reg - KW'(1);
                if (cnt_reg == KW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/bap_bitmap.sv */
module bap_bitmap #(
    parameter int WINDOW_MAX = 1024,
    localparam int IXW = $clog2(WINDOW_MAX + 1),
    localparam int CW  = $clog2(2 * WINDOW_MAX + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bap_pkg::bm_cmd_t  cmd,
    input  logic [IXW-1:0]    lo,
    input  logic [IXW-1:0]    hi,
    input  logic [IXW-1:0]    shift,
    output logic              done,
    output logic [CW-1:0]     count
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int JW = $clog2(2 * WINDOW_MAX + 1);

    logic map_reg [WINDOW_MAX];

    logic                 busy_reg;
    logic                 done_reg;
    logic                 pend_reg;
    logic                 va_reg;
    logic                 vb_reg;
    logic                 rd_a_reg;
    logic                 rd_b_reg;
    bap_pkg::bm_op_t      op_reg;
    logic [JW-1:0]        j_reg;
    logic [JW-1:0]        stop_reg;
    logic [IXW-1:0]       sh_reg;
    logic [CW-1:0]        acc_reg;

    logic                 issue;
    logic                 we;
    logic                 wbit;
    logic [JW-1:0]        jb;
    logic                 va;
    logic                 vb;

    assign issue = busy_reg && (j_reg < stop_reg);
    assign we    = issue && ((op_reg == bap_pkg::BM_FILL) || (op_reg == bap_pkg::BM_CLEAR));
    assign wbit  = (op_reg == bap_pkg::BM_FILL);
    assign jb    = j_reg - JW'(sh_reg);
    assign va    = j_reg < JW'(WINDOW_MAX);
    assign vb    = (j_reg >= JW'(sh_reg)) && (jb < JW'(WINDOW_MAX));

    always_ff @(posedge aclk) begin
        if (we) begin
            map_reg[j_reg[AW-1:0]] <= wbit;
        end
        rd_a_reg <= map_reg[j_reg[AW-1:0]];
        rd_b_reg <= map_reg[jb[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            pend_reg <= issue && (op_reg == bap_pkg::BM_COUNT);
            va_reg   <= va;
            vb_reg   <= vb;
            if (cmd.go) begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                sh_reg   <= shift;
                acc_reg  <= '0;
                unique case (cmd.op)
                    bap_pkg::BM_FILL: begin
                        j_reg    <= JW'(lo);
                        stop_reg <= JW'(hi);
                    end
                    bap_pkg::BM_CLEAR: begin
                        j_reg    <= '0;
                        stop_reg <= JW'(WINDOW_MAX);
                    end
                    bap_pkg::BM_COUNT: begin
                        j_reg    <= '0;
                        stop_reg <= JW'(WINDOW_MAX) + JW'(shift);
                    end
                    default: begin
                        j_reg    <= '0;
                        stop_reg <= '0;
                    end
                endcase
            end else if (busy_reg) begin
                if (issue) begin
                    j_reg <= j_reg + JW'(1);
                end
                if (pend_reg) begin
                    acc_reg <= acc_reg + CW'((rd_a_reg & va_reg) ^ (rd_b_reg & vb_reg));
                end
                if (!issue && !pend_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign count = acc_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("bit map unit signals done while still busy");

endmodule

/* rtl/bitwise_autocorrelation_pitch_unit.sv */
// Bitwise autocorrelation pitch unit. Takes one signed 16-bit audio word per handshake and
// emits one result word at the last sample of each window of window_len samples (window_len
// below 2 acts as 2, above WINDOW_MAX as WINDOW_MAX; a write takes effect at once). Positive
// half-cycles have their start times interpolated in Q.FRAC_BITS and mark their samples in a
// bit map; for every pair of crossing starts whose gap lies in (0, window_len] the map is
// compared with itself shifted by the rounded gap, and the gap with the first strictly
// smallest mismatch is reported (found = 0, period and mismatch zero, if no pair exists).
// Each sample runs the divider where a crossing opens or closes, and a closing crossing that
// is stored marks its samples in the bit map. After the window the search reads the start
// times of each pair, skips the pairs out of range and scores the rest; the mismatch for a
// shift is counted only the first time that shift is seen and is then cached, as the bit map
// memory is walked one position per cycle. After reset and after every window a clearing
// pass wipes the bit map and the shift cost cache; no word is taken meanwhile, but
// configuration writes are.
module bitwise_autocorrelation_pitch_unit #(
    parameter int WINDOW_MAX    = 1024,
    parameter int MAX_CROSSINGS = 512,
    parameter int FRAC_BITS     = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [bap_pkg::WLEN_W-1:0]             cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [bap_pkg::SAMPLE_W-1:0]    s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [bap_pkg::PERIOD_W-1:0]           m_period_q8,
    output logic [bap_pkg::MISMATCH_W-1:0]         m_mismatch,
    output logic                                   m_found
);

    localparam int IXW = $clog2(WINDOW_MAX + 1);
    localparam int TW  = IXW + FRAC_BITS;
    localparam int CW  = $clog2(2 * WINDOW_MAX + 1);
    localparam int CIW = $clog2(MAX_CROSSINGS);
    localparam int CCW = $clog2(MAX_CROSSINGS + 1);
    localparam int QW  = FRAC_BITS + 1;
    localparam int SW  = bap_pkg::SAMPLE_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EVAL     = 4'd1;
    localparam logic [3:0] ST_DIV_ST   = 4'd2;
    localparam logic [3:0] ST_DIV_END  = 4'd3;
    localparam logic [3:0] ST_FILL     = 4'd4;
    localparam logic [3:0] ST_ADV      = 4'd5;
    localparam logic [3:0] ST_S_RD     = 4'd6;
    localparam logic [3:0] ST_S_CMP    = 4'd7;
    localparam logic [3:0] ST_S_CRD    = 4'd8;
    localparam logic [3:0] ST_S_CNT    = 4'd9;
    localparam logic [3:0] ST_FIN      = 4'd10;
    localparam logic [3:0] ST_CLR_GO   = 4'd11;
    localparam logic [3:0] ST_CLR_WAIT = 4'd12;

    // Memories: crossing start times, and the per-shift cost cache {known, cost}
    logic [TW-1:0] start_mem [MAX_CROSSINGS];
    logic [CW:0]   cost_mem  [WINDOW_MAX + 1];

    logic [3:0]                 state_reg,   state_next;
    logic [bap_pkg::WLEN_W-1:0] wlen_reg,    wlen_next;
    logic signed [SW-1:0]       s_reg,       s_next;
    logic signed [SW-1:0]       prev_reg,    prev_next;
    logic                       inside_reg,  inside_next;
    logic [TW-1:0]              open_reg,    open_next;
    logic [IXW-1:0]             idx_reg,     idx_next;
    logic [CCW-1:0]             cnt_reg,     cnt_next;
    logic [CIW-1:0]             a_reg,       a_next;
    logic [CIW-1:0]             b_reg,       b_next;
    logic [TW-1:0]              gap_reg,     gap_next;
    logic [IXW-1:0]             sh_reg,      sh_next;
    logic [CW-1:0]              best_reg,    best_next;
    logic [TW-1:0]              bgap_reg,    bgap_next;
    logic                       found_reg,   found_next;
    logic [IXW-1:0]             clr_idx_reg, clr_idx_next;
    logic                       clr_fin_reg, clr_fin_next;
    logic                       bm_seen_reg, bm_seen_next;
    logic                       m_valid_reg, m_valid_next;
    logic [bap_pkg::PERIOD_W-1:0]   m_period_reg,   m_period_next;
    logic [bap_pkg::MISMATCH_W-1:0] m_mismatch_reg, m_mismatch_next;
    logic                       m_found_reg, m_found_next;

    logic [TW-1:0]              sa_rd_reg;
    logic [TW-1:0]              sb_rd_reg;
    logic [CW:0]                cost_rd_reg;

    logic [IXW-1:0]             eff_len;
    logic [TW-1:0]              limit;
    logic [IXW-1:0]             idx_p1;
    logic signed [SW:0]         s17;
    logic signed [SW:0]         prev17;
    logic signed [SW:0]         neg17;
    logic signed [SW:0]         s_minus_p;
    logic signed [SW:0]         p_minus_s;
    logic [SW-1:0]              div_mag;
    logic [SW-1:0]              div_span;
    logic                       div_go;
    logic                       div_done;
    logic [QW-1:0]              div_quo;
    logic [TW-1:0]              time_q;
    logic [IXW-1:0]             end_int;
    logic [IXW-1:0]             fill_hi;
    logic [IXW-1:0]             fill_lo;
    logic [TW-1:0]              gap;
    logic [TW:0]                rnd;
    logic [IXW:0]               sh_raw;
    logic [IXW-1:0]             sh_c;

    bap_pkg::bm_cmd_t           bm_cmd;
    logic                       bm_done;
    logic [CW-1:0]              bm_count;

    logic                       cost_we;
    logic [IXW-1:0]             cost_wa;
    logic [CW:0]                cost_wd;
    logic                       start_we;
    logic                       step_a;
    logic                       step_b;
    logic                       upd;
    logic [CW-1:0]              upd_cost;

    // Clamp the window length register into the supported range
    always_comb begin
        if (wlen_reg < bap_pkg::WLEN_W'(2)) begin
            eff_len = IXW'(2);
        end else if (32'(wlen_reg) > WINDOW_MAX) begin
            eff_len = IXW'(WINDOW_MAX);
        end else begin
            eff_len = IXW'(wlen_reg);
        end
    end

    assign limit  = {eff_len, {FRAC_BITS{1'b0}}};
    assign idx_p1 = idx_reg + IXW'(1);

    // Divider operands: magnitude of the current sample over the step across zero
    assign s17       = {s_reg[SW-1], s_reg};
    assign prev17    = {prev_reg[SW-1], prev_reg};
    assign neg17     = -s17;
    assign s_minus_p = s17 - prev17;
    assign p_minus_s = prev17 - s17;
    assign div_mag   = inside_reg ? neg17[SW-1:0] : s17[SW-1:0];
    assign div_span  = inside_reg ? p_minus_s[SW-1:0] : s_minus_p[SW-1:0];

    // Crossing time, one sample late so that it never goes negative
    assign time_q  = {idx_p1, {FRAC_BITS{1'b0}}} - TW'(div_quo);
    assign end_int = time_q[TW-1:FRAC_BITS];
    assign fill_hi = (end_int > IXW'(WINDOW_MAX)) ? IXW'(WINDOW_MAX) : end_int;
    assign fill_lo = open_reg[TW-1:FRAC_BITS];

    // Pair gap and its shift, halves rounded up
    assign gap    = sb_rd_reg - sa_rd_reg;
    assign rnd    = {1'b0, gap} + (TW + 1)'(2 ** (FRAC_BITS - 1));
    assign sh_raw = rnd[TW:FRAC_BITS];
    assign sh_c   = (sh_raw > (IXW + 1)'(WINDOW_MAX)) ? IXW'(WINDOW_MAX) : sh_raw[IXW-1:0];

    bap_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (div_go),
        .mag     (div_mag),
        .span    (div_span),
        .done    (div_done),
        .quo     (div_quo)
    );

    bap_bitmap #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (bm_cmd),
        .lo      (fill_lo),
        .hi      (fill_hi),
        .shift   (sh_reg),
        .done    (bm_done),
        .count   (bm_count)
    );

    always_ff @(posedge aclk) begin
        if (cost_we) begin
            cost_mem[cost_wa] <= cost_wd;
        end
        cost_rd_reg <= cost_mem[sh_c];
        if (start_we) begin
            start_mem[cnt_reg[CIW-1:0]] <= open_reg;
        end
        sa_rd_reg <= start_mem[a_reg];
        sb_rd_reg <= start_mem[b_reg];
    end

    always_comb begin
        state_next      = state_reg;
        wlen_next       = cfg_we ? cfg_wdata : wlen_reg;
        s_next          = s_reg;
        prev_next       = prev_reg;
        inside_next     = inside_reg;
        open_next       = open_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        gap_next        = gap_reg;
        sh_next         = sh_reg;
        best_next       = best_reg;
        bgap_next       = bgap_reg;
        found_next      = found_reg;
        clr_idx_next    = clr_idx_reg;
        clr_fin_next    = clr_fin_reg;
        bm_seen_next    = bm_seen_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_period_next   = m_period_reg;
        m_mismatch_next = m_mismatch_reg;
        m_found_next    = m_found_reg;
        bm_cmd          = '0;
        div_go          = 1'b0;
        cost_we         = 1'b0;
        cost_wa         = clr_idx_reg;
        cost_wd         = '0;
        start_we        = 1'b0;
        step_a          = 1'b0;
        step_b          = 1'b0;
        upd             = 1'b0;
        upd_cost        = '0;

        unique case (state_reg)
            ST_CLR_GO: begin
                bm_cmd.go    = 1'b1;
                bm_cmd.op    = bap_pkg::BM_CLEAR;
                clr_idx_next = '0;
                clr_fin_next = 1'b0;
                bm_seen_next = 1'b0;
                state_next   = ST_CLR_WAIT;
            end
            ST_CLR_WAIT: begin
                // Wipe the cost cache alongside the bit map sweep
                cost_we = !clr_fin_reg;
                if (clr_idx_reg == IXW'(WINDOW_MAX)) begin
                    clr_fin_next = 1'b1;
                end else begin
                    clr_idx_next = clr_idx_reg + IXW'(1);
                end
                if (bm_done) begin
                    bm_seen_next = 1'b1;
                end
                if (clr_fin_reg && bm_seen_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    s_next     = s_sample;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (inside_reg) begin
                    if (s_reg < 0) begin
                        div_go     = 1'b1;
                        state_next = ST_DIV_END;
                    end else begin
                        state_next = ST_ADV;
                    end
                end else if ((prev_reg <= 0) && (s_reg > 0)) begin
                    div_go     = 1'b1;
                    state_next = ST_DIV_ST;
                end else begin
                    state_next = ST_ADV;
                end
            end
            ST_DIV_ST: begin
                if (div_done) begin
                    open_next   = time_q;
                    inside_next = 1'b1;
                    state_next  = ST_ADV;
                end
            end
            ST_DIV_END: begin
                if (div_done) begin
                    inside_next = 1'b0;
                    // Drop the crossing when the start store is full
                    if (cnt_reg < CCW'(MAX_CROSSINGS)) begin
                        bm_cmd.go  = 1'b1;
                        bm_cmd.op  = bap_pkg::BM_FILL;
                        start_we   = 1'b1;
                        cnt_next   = cnt_reg + CCW'(1);
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_FILL: begin
                if (bm_done) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                prev_next = s_reg;
                idx_next  = idx_p1;
                if (idx_p1 >= eff_len) begin
                    a_next     = '0;
                    b_next     = '0;
                    best_next  = '1;
                    bgap_next  = '0;
                    found_next = 1'b0;
                    state_next = (cnt_reg == '0) ? ST_FIN : ST_S_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_S_RD: begin
                state_next = ST_S_CMP;
            end
            ST_S_CMP: begin
                if (sb_rd_reg <= sa_rd_reg) begin
                    step_b = 1'b1;
                end else if (gap > limit) begin
                    step_a = 1'b1;
                end else begin
                    gap_next   = gap;
                    sh_next    = sh_c;
                    state_next = ST_S_CRD;
                end
            end
            ST_S_CRD: begin
                if (cost_rd_reg[CW]) begin
                    upd      = 1'b1;
                    upd_cost = cost_rd_reg[CW-1:0];
                    step_b   = 1'b1;
                end else begin
                    bm_cmd.go  = 1'b1;
                    bm_cmd.op  = bap_pkg::BM_COUNT;
                    state_next = ST_S_CNT;
                end
            end
            ST_S_CNT: begin
                if (bm_done) begin
                    cost_we  = 1'b1;
                    cost_wa  = sh_reg;
                    cost_wd  = {1'b1, bm_count};
                    upd      = 1'b1;
                    upd_cost = bm_count;
                    step_b   = 1'b1;
                end
            end
            ST_FIN: begin
                // Hold until the output slot is free, then restart the window
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_period_next   = bap_pkg::PERIOD_W'(bgap_reg);
                    m_mismatch_next = found_reg ? bap_pkg::MISMATCH_W'(best_reg) : '0;
                    m_found_next    = found_reg;
                    cnt_next        = '0;
                    prev_next       = '0;
                    inside_next     = 1'b0;
                    open_next       = '0;
                    idx_next        = '0;
                    state_next      = ST_CLR_GO;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (upd && (upd_cost < best_reg)) begin
            best_next  = upd_cost;
            bgap_next  = gap_reg;
            found_next = 1'b1;
        end

        // Advance the pair walk: next partner, or next first crossing
        if (step_b) begin
            if (CCW'(b_reg) + CCW'(1) == cnt_reg) begin
                step_a = 1'b1;
            end else begin
                b_next     = b_reg + CIW'(1);
                state_next = ST_S_RD;
            end
        end
        if (step_a) begin
            if (CCW'(a_reg) + CCW'(1) == cnt_reg) begin
                state_next = ST_FIN;
            end else begin
                a_next     = a_reg + CIW'(1);
                b_next     = '0;
                state_next = ST_S_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR_GO;
            wlen_reg    <= bap_pkg::WLEN_RESET;
            prev_reg    <= '0;
            inside_reg  <= 1'b0;
            open_reg    <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            clr_idx_reg <= '0;
            clr_fin_reg <= 1'b0;
            bm_seen_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wlen_reg    <= wlen_next;
            prev_reg    <= prev_next;
            inside_reg  <= inside_next;
            open_reg    <= open_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            clr_idx_reg <= clr_idx_next;
            clr_fin_reg <= clr_fin_next;
            bm_seen_reg <= bm_seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg          <= s_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        gap_reg        <= gap_next;
        sh_reg         <= sh_next;
        best_reg       <= best_next;
        bgap_reg       <= bgap_next;
        found_reg      <= found_next;
        m_period_reg   <= m_period_next;
        m_mismatch_reg <= m_mismatch_next;
        m_found_reg    <= m_found_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_period_q8 = m_period_reg;
    assign m_mismatch  = m_mismatch_reg;
    assign m_found     = m_found_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CCW'(MAX_CROSSINGS))
        else $error("crossing count beyond store depth");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_period_reg == '0) && (m_mismatch_reg == '0))
        else $error("result without a pair carries a non-zero period or mismatch");

    a_bm_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        bm_done |-> (state_reg == ST_FILL) || (state_reg == ST_CLR_WAIT)
                    || (state_reg == ST_S_CNT))
        else $error("bit map unit finished while nothing waits for it");

endmodule
